@@ rtl/efcs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the Ethernet frame classifier with statistics.
// No dependencies; imported by every module of the block.
package efcs_pkg;

	localparam int LISTENER_SLOTS = 4;
	localparam int SLOT_W         = 2;
	localparam int NUM_COUNTERS   = 13;
	localparam int CNT_IDX_W      = 4;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

	localparam logic [10:0] LEN_ETH        = 11'd14;
	localparam logic [10:0] LEN_ETH_IP     = 11'd34;
	localparam logic [10:0] LEN_ETH_IP_UDP = 11'd42;

	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	// configuration register indexes
	localparam logic [2:0] CFG_LISTENER_COUNT = 3'd0;
	localparam logic [2:0] CFG_PORT_BASE      = 3'd1;

	// statistics counter indexes
	localparam logic [CNT_IDX_W-1:0] CNT_TX_TOTAL = 4'd0;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_TOTAL = 4'd1;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_DROP  = 4'd2;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_ICMP  = 4'd3;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_UDP   = 4'd4;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_TCP   = 4'd5;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_ARP   = 4'd6;
	localparam logic [CNT_IDX_W-1:0] CNT_RX_OTHER = 4'd7;
	localparam logic [CNT_IDX_W-1:0] CNT_TX_ICMP  = 4'd8;
	localparam logic [CNT_IDX_W-1:0] CNT_TX_UDP   = 4'd9;
	localparam logic [CNT_IDX_W-1:0] CNT_TX_TCP   = 4'd10;
	localparam logic [CNT_IDX_W-1:0] CNT_TX_ARP   = 4'd11;
	localparam logic [CNT_IDX_W-1:0] CNT_TX_OTHER = 4'd12;

	typedef enum logic [2:0] {
		CLS_ARP   = 3'd0,
		CLS_ICMP  = 3'd1,
		CLS_TCP   = 3'd2,
		CLS_UDP   = 3'd3,
		CLS_OTHER = 3'd4,
		CLS_SHORT = 3'd5
	} cls_t;

	typedef enum logic [2:0] {
		TGT_NONE = 3'd0,
		TGT_ARP  = 3'd1,
		TGT_ICMP = 3'd2,
		TGT_TCP  = 3'd3,
		TGT_UDP  = 3'd4
	} tgt_t;

	typedef enum logic {
		ACT_CLASSIFY = 1'b0,
		ACT_READ     = 1'b1
	} act_t;

	typedef struct packed {
		logic        action;
		logic        is_transmit;
		logic [10:0] frame_length;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [15:0] udp_dest_port;
		logic [3:0]  counter_index;
	} hdr_t;

	typedef struct packed {
		cls_t        frame_class;
		tgt_t        dispatch_target;
		logic [1:0]  listener_slot;
		logic        dropped;
		logic [63:0] counter_value;
	} res_t;

	// word passed from front to back through the queue
	typedef struct packed {
		logic                    is_read;
		logic [CNT_IDX_W-1:0]    counter_index;
		logic [NUM_COUNTERS-1:0] inc_mask;
		cls_t                    frame_class;
		tgt_t                    dispatch_target;
		logic [SLOT_W-1:0]       listener_slot;
		logic                    dropped;
	} qword_t;

endpackage

@@ rtl/efcs_front.sv @@
`timescale 1ns / 1ps
// Front end: listener configuration registers, frame classification and dispatch.
// Depends on efcs_pkg.
module efcs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  efcs_pkg::hdr_t    hdr,
	output efcs_pkg::qword_t  qword
);
	import efcs_pkg::*;

	logic [2:0]  listener_count_q;
	logic [15:0] listener_port_q [LISTENER_SLOTS];
	logic [2:0]  port_sel;

	assign port_sel = cfg_index - CFG_PORT_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listener_count_q <= '0;
			for (int i = 0; i < LISTENER_SLOTS; i++) begin
				listener_port_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_LISTENER_COUNT) begin
				listener_count_q <= cfg_data[2:0];
			end else if (cfg_index >= CFG_PORT_BASE &&
			             cfg_index < CFG_PORT_BASE + 3'(LISTENER_SLOTS)) begin
				listener_port_q[port_sel[SLOT_W-1:0]] <= cfg_data;
			end
		end
	end

	cls_t              cls;
	logic [2:0]        n_eff;
	logic              hit;
	logic [SLOT_W-1:0] hit_slot;

	always_comb begin
		priority if (hdr.frame_length < LEN_ETH)                 cls = CLS_SHORT;
		else if (hdr.ether_type == ETYPE_ARP)                    cls = CLS_ARP;
		else if (hdr.ether_type != ETYPE_IPV4 ||
		         hdr.frame_length < LEN_ETH_IP)                  cls = CLS_OTHER;
		else if (hdr.ip_protocol == PROTO_ICMP)                  cls = CLS_ICMP;
		else if (hdr.ip_protocol == PROTO_TCP)                   cls = CLS_TCP;
		else if (hdr.ip_protocol == PROTO_UDP)                   cls = CLS_UDP;
		else                                                     cls = CLS_OTHER;
	end

	// first enabled slot wins: scan from the top so the lowest match lands last
	always_comb begin
		n_eff = (listener_count_q > 3'(LISTENER_SLOTS)) ? 3'(LISTENER_SLOTS)
		                                                : listener_count_q;
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = LISTENER_SLOTS - 1; i >= 0; i--) begin
			if (3'(i) < n_eff && listener_port_q[i] == hdr.udp_dest_port) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(i);
			end
		end
		if (hdr.frame_length < LEN_ETH_IP_UDP) begin
			hit = 1'b0;
		end
	end

	always_comb begin
		qword = '0;
		qword.frame_class     = CLS_ARP;
		qword.dispatch_target = TGT_NONE;
		qword.counter_index   = hdr.counter_index;
		if (hdr.action == ACT_READ) begin
			qword.is_read = 1'b1;
		end else begin
			qword.frame_class = cls;
			if (hdr.is_transmit) begin
				qword.inc_mask[CNT_TX_TOTAL] = 1'b1;
				unique case (cls)
					CLS_ARP:   qword.inc_mask[CNT_TX_ARP]   = 1'b1;
					CLS_ICMP:  qword.inc_mask[CNT_TX_ICMP]  = 1'b1;
					CLS_TCP:   qword.inc_mask[CNT_TX_TCP]   = 1'b1;
					CLS_UDP:   qword.inc_mask[CNT_TX_UDP]   = 1'b1;
					CLS_OTHER: qword.inc_mask[CNT_TX_OTHER] = 1'b1;
					default:   ;
				endcase
			end else begin
				qword.inc_mask[CNT_RX_TOTAL] = 1'b1;
				unique case (cls)
					CLS_ARP: begin
						qword.inc_mask[CNT_RX_ARP] = 1'b1;
						qword.dispatch_target      = TGT_ARP;
					end
					CLS_ICMP: begin
						qword.inc_mask[CNT_RX_ICMP] = 1'b1;
						qword.dispatch_target       = TGT_ICMP;
					end
					CLS_TCP: begin
						qword.inc_mask[CNT_RX_TCP] = 1'b1;
						qword.dispatch_target      = TGT_TCP;
					end
					CLS_UDP: begin
						qword.inc_mask[CNT_RX_UDP] = 1'b1;
						if (hit) begin
							qword.dispatch_target = TGT_UDP;
							qword.listener_slot   = hit_slot;
						end else begin
							qword.dropped = 1'b1;
						end
					end
					CLS_OTHER: begin
						qword.inc_mask[CNT_RX_OTHER] = 1'b1;
						qword.dropped                = 1'b1;
					end
					default: qword.dropped = 1'b1;
				endcase
				qword.inc_mask[CNT_RX_DROP] = qword.dropped;
			end
		end
	end

endmodule

@@ rtl/efcs_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of classified words between front and back.
// Depends on efcs_pkg.
module efcs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  efcs_pkg::qword_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output efcs_pkg::qword_t rdata
);
	import efcs_pkg::*;

	qword_t            mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rvalid = (count_q != '0);
	assign rdata  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full || pop)
		else $error("queue push while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> rvalid)
		else $error("queue pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count overflow");

endmodule

@@ rtl/efcs_back.sv @@
`timescale 1ns / 1ps
// Back end: statistics counters, counter reads and the result output register.
// Depends on efcs_pkg.
module efcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  efcs_pkg::qword_t q_word,
	output logic             q_pop,
	output logic             res_valid,
	input  logic             res_ready,
	output efcs_pkg::res_t   res
);
	import efcs_pkg::*;

	logic [63:0] cnt_q [NUM_COUNTERS];
	logic        res_valid_q;
	res_t        res_q;
	logic [63:0] rd_value;

	assign q_pop     = q_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// reads see every earlier word since words leave the queue in order
	assign rd_value = (q_word.counter_index < CNT_IDX_W'(NUM_COUNTERS))
	                  ? cnt_q[q_word.counter_index] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COUNTERS; i++) begin
				cnt_q[i] <= '0;
			end
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				for (int i = 0; i < NUM_COUNTERS; i++) begin
					if (q_word.inc_mask[i]) begin
						cnt_q[i] <= cnt_q[i] + 64'd1;
					end
				end
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.frame_class     <= q_word.frame_class;
			res_q.dispatch_target <= q_word.dispatch_target;
			res_q.listener_slot   <= q_word.listener_slot;
			res_q.dropped         <= q_word.dropped;
			res_q.counter_value   <= q_word.is_read ? rd_value : '0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |=> res_valid)
		else $error("popped word did not reach the output");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.dropped |-> res.dispatch_target == TGT_NONE)
		else $error("dropped word has a dispatch target");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.dispatch_target != TGT_UDP |-> res.listener_slot == '0)
		else $error("listener slot set without udp dispatch");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_word.is_read |-> q_word.inc_mask == '0)
		else $error("counter read also bumps a counter");

endmodule

@@ rtl/ethernet_frame_classifier_stats.sv @@
`timescale 1ns / 1ps
// A header accepted into the queue is registered in the queue memory, then in the
// back end's result register. Throughput: one header per cycle while the output is
// not stalled, set by the combinational front classify and the per-counter back
// incrementers. A two-word queue between them lets either side stall alone.
// Reset (arst_n low) clears all counters, listener registers, queue and output valid.
module ethernet_frame_classifier_stats (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            hdr_valid,
	output logic            hdr_ready,
	input  efcs_pkg::hdr_t  hdr,
	output logic            res_valid,
	input  logic            res_ready,
	output efcs_pkg::res_t  res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data
);
	import efcs_pkg::*;

	qword_t front_word;
	qword_t back_word;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   push;

	assign cfg_ready = 1'b1;
	assign hdr_ready = !q_full;
	assign push      = hdr_valid && hdr_ready;

	efcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.hdr       (hdr),
		.qword     (front_word)
	);

	efcs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_word),
		.full   (q_full),
		.pop    (q_pop),
		.rvalid (q_valid),
		.rdata  (back_word)
	);

	efcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_word    (back_word),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for ethernet_frame_classifier_stats: directed and random frame headers
// and counter reads under several listener settings, checked by an in-bench predictor.
// Depends on rtl/efcs_pkg.sv and rtl/ethernet_frame_classifier_stats.sv.
module tb_top;
	import efcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 53;

	// predicts one result word per header and checks the block's results in order
	class frame_stats_scoreboard;
		logic [63:0] stats [NUM_COUNTERS];
		logic [2:0]  n_listeners;
		logic [15:0] port_reg [LISTENER_SLOTS];
		res_t        pending [$];
		int          errors;

		function new();
			foreach (stats[i]) stats[i] = '0;
			foreach (port_reg[i]) port_reg[i] = '0;
			n_listeners = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			if (idx == CFG_LISTENER_COUNT) begin
				n_listeners = data[2:0];
			end else if (idx >= CFG_PORT_BASE && idx < CFG_PORT_BASE + LISTENER_SLOTS) begin
				port_reg[idx - CFG_PORT_BASE] = data;
			end
		endfunction

		function cls_t class_of(logic [10:0] len, logic [15:0] etype, logic [7:0] proto);
			if (len < LEN_ETH) return CLS_SHORT;
			if (etype == ETYPE_ARP) return CLS_ARP;
			if (etype != ETYPE_IPV4 || len < LEN_ETH_IP) return CLS_OTHER;
			case (proto)
				PROTO_ICMP: return CLS_ICMP;
				PROTO_TCP:  return CLS_TCP;
				PROTO_UDP:  return CLS_UDP;
				default:    return CLS_OTHER;
			endcase
		endfunction

		function void note_header(hdr_t h);
			res_t r;
			cls_t c;
			int   n;
			int   i;
			r = '0;
			if (h.action == ACT_READ) begin
				if (h.counter_index < NUM_COUNTERS) r.counter_value = stats[h.counter_index];
				pending.push_back(r);
				return;
			end
			c = class_of(h.frame_length, h.ether_type, h.ip_protocol);
			r.frame_class = c;
			if (h.is_transmit) begin
				stats[CNT_TX_TOTAL]++;
				case (c)
					CLS_ARP:   stats[CNT_TX_ARP]++;
					CLS_ICMP:  stats[CNT_TX_ICMP]++;
					CLS_TCP:   stats[CNT_TX_TCP]++;
					CLS_UDP:   stats[CNT_TX_UDP]++;
					CLS_OTHER: stats[CNT_TX_OTHER]++;
					default: ;
				endcase
			end else begin
				stats[CNT_RX_TOTAL]++;
				case (c)
					CLS_ARP: begin
						stats[CNT_RX_ARP]++;
						r.dispatch_target = TGT_ARP;
					end
					CLS_ICMP: begin
						stats[CNT_RX_ICMP]++;
						r.dispatch_target = TGT_ICMP;
					end
					CLS_TCP: begin
						stats[CNT_RX_TCP]++;
						r.dispatch_target = TGT_TCP;
					end
					CLS_UDP: begin
						stats[CNT_RX_UDP]++;
						// listener count saturates at the slot count; first match wins
						n = (n_listeners > LISTENER_SLOTS) ? LISTENER_SLOTS : n_listeners;
						if (h.frame_length >= LEN_ETH_IP_UDP) begin
							for (i = 0; i < n; i++) begin
								if (port_reg[i] == h.udp_dest_port) begin
									r.dispatch_target = TGT_UDP;
									r.listener_slot = 2'(i);
									break;
								end
							end
						end
						if (r.dispatch_target == TGT_NONE) r.dropped = 1'b1;
					end
					CLS_OTHER: begin
						stats[CNT_RX_OTHER]++;
						r.dropped = 1'b1;
					end
					default: r.dropped = 1'b1;
				endcase
				if (r.dropped) stats[CNT_RX_DROP]++;
			end
			pending.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: expected nothing, got %p", $time, got);
				return;
			end
			want = pending.pop_front();
			compare_field("frame_class", want.frame_class, got.frame_class);
			compare_field("dispatch_target", want.dispatch_target, got.dispatch_target);
			compare_field("listener_slot", want.listener_slot, got.listener_slot);
			compare_field("dropped", want.dropped, got.dropped);
			compare_field("counter_value", want.counter_value, got.counter_value);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        hdr_valid;
	logic        hdr_ready;
	hdr_t        hdr;
	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	frame_stats_scoreboard sb = new();
	bit fast_sender;
	bit fast_receiver;
	int idle_cycles;

	ethernet_frame_classifier_stats dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr       (hdr),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((hdr_valid && hdr_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[ethernet_frame_classifier_stats] ERROR");
			$finish;
		end
	end

	// result side: random stall before each word, with bursts of none
	initial begin
		int stall;
		int words;
		words = 0;
		forever begin
			if (words % 40 == 0) fast_receiver = ($urandom_range(0, 2) == 0);
			stall = fast_receiver ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			sb.check_result(res);
			words++;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(logic [2:0] count, logic [15:0] ports [LISTENER_SLOTS]);
		for (int i = 0; i < LISTENER_SLOTS; i++) write_reg(CFG_PORT_BASE + 3'(i), ports[i]);
		write_reg(CFG_LISTENER_COUNT, {13'd0, count});
		cfg_valid <= 1'b0;
	endtask

	task automatic send_header(hdr_t h);
		int gap;
		gap = fast_sender ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			hdr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr <= h;
		hdr_valid <= 1'b1;
		do @(posedge clk); while (!hdr_ready);
		sb.note_header(h);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		hdr_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic hdr_t make_header(act_t act, logic tx, logic [10:0] len,
			logic [15:0] etype, logic [7:0] proto, logic [15:0] port, logic [3:0] idx);
		hdr_t h;
		h.action = act;
		h.is_transmit = tx;
		h.frame_length = len;
		h.ether_type = etype;
		h.ip_protocol = proto;
		h.udp_dest_port = port;
		h.counter_index = idx;
		return h;
	endfunction

	// mostly well-formed IPv4/ARP headers, the rest boundary lengths and noise
	function automatic hdr_t random_header();
		hdr_t h;
		int   edge_lens [8] = '{0, 13, 14, 33, 34, 41, 42, 2047};
		h.action = ($urandom_range(0, 4) == 0) ? ACT_READ : ACT_CLASSIFY;
		h.is_transmit = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0:       h.frame_length = 11'(edge_lens[$urandom_range(0, 7)]);
			1:       h.frame_length = 11'($urandom_range(0, 2047));
			default: h.frame_length = 11'($urandom_range(42, 1518));
		endcase
		case ($urandom_range(0, 4))
			0:       h.ether_type = 16'($urandom);
			1:       h.ether_type = ETYPE_ARP;
			default: h.ether_type = ETYPE_IPV4;
		endcase
		case ($urandom_range(0, 5))
			0:       h.ip_protocol = 8'($urandom);
			1:       h.ip_protocol = PROTO_ICMP;
			2:       h.ip_protocol = PROTO_TCP;
			default: h.ip_protocol = PROTO_UDP;
		endcase
		if ($urandom_range(0, 1)) h.udp_dest_port = sb.port_reg[$urandom_range(0, LISTENER_SLOTS - 1)];
		else h.udp_dest_port = 16'($urandom);
		h.counter_index = 4'($urandom_range(0, 15));
		return h;
	endfunction

	initial begin
		logic [15:0] ports [LISTENER_SLOTS];
		logic [2:0]  counts [PHASES] = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd3, 3'd6};
		arst_n <= 1'b0;
		hdr_valid <= 1'b0;
		hdr <= '0;
		res_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idle_cycles <= 0;
		fast_sender = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slots 2 and 3 share a port so the lower slot must win
		ports = '{16'h0000, 16'hFFFF, 16'h1234, 16'h1234};
		configure(3'd4, ports);
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd0, 16'h0000, 8'd0, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b1, 11'd13, ETYPE_ARP, 8'd0, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd14, ETYPE_ARP, 8'd0, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b1, 11'd2047, ETYPE_ARP, 8'd0, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd33, ETYPE_IPV4, PROTO_ICMP, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd34, ETYPE_IPV4, PROTO_ICMP, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b1, 11'd34, ETYPE_IPV4, PROTO_ICMP, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd60, ETYPE_IPV4, PROTO_TCP, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b1, 11'd1514, ETYPE_IPV4, PROTO_TCP, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd41, ETYPE_IPV4, PROTO_UDP, 16'h0000, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd42, ETYPE_IPV4, PROTO_UDP, 16'h0000, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd42, ETYPE_IPV4, PROTO_UDP, 16'hFFFF, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd100, ETYPE_IPV4, PROTO_UDP, 16'h1234, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd100, ETYPE_IPV4, PROTO_UDP, 16'h4321, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b1, 11'd100, ETYPE_IPV4, PROTO_UDP, 16'h1234, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd100, ETYPE_IPV4, 8'hFF, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b0, 11'd100, 16'hFFFF, PROTO_UDP, 16'd0, 4'd0));
		send_header(make_header(ACT_CLASSIFY, 1'b1, 11'd100, 16'h86DD, PROTO_TCP, 16'd0, 4'd0));
		send_header(make_header(ACT_READ, 1'b0, 11'd0, 16'd0, 8'd0, 16'd0, CNT_TX_TOTAL));
		send_header(make_header(ACT_READ, 1'b0, 11'd0, 16'd0, 8'd0, 16'd0, CNT_RX_TOTAL));
		send_header(make_header(ACT_READ, 1'b0, 11'd0, 16'd0, 8'd0, 16'd0, CNT_RX_DROP));
		send_header(make_header(ACT_READ, 1'b0, 11'd0, 16'd0, 8'd0, 16'd0, CNT_TX_OTHER));
		send_header(make_header(ACT_READ, 1'b0, 11'd0, 16'd0, 8'd0, 16'd0, 4'd13));
		send_header(make_header(ACT_READ, 1'b0, 11'd0, 16'd0, 8'd0, 16'd0, 4'd15));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < LISTENER_SLOTS; i++) begin
				case ($urandom_range(0, 4))
					0:       ports[i] = 16'h0000;
					1:       ports[i] = 16'hFFFF;
					2:       ports[i] = (i > 0) ? ports[i - 1] : 16'($urandom);
					default: ports[i] = 16'($urandom);
				endcase
			end
			configure(counts[p], ports);
			fast_sender = ($urandom_range(0, 2) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) send_header(random_header());
			drain();
		end

		if (sb.errors == 0) begin
			$display("[ethernet_frame_classifier_stats] OK");
		end else begin
			$display("[ethernet_frame_classifier_stats] ERROR");
		end
		$finish;
	end
endmodule
